// ----- src/bpu_pkg.sv -----
package bpu_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CHAN_W    = 8;
    localparam int COORD_W   = 12;
    localparam int DIM_W     = 13;
    localparam int MASK_W    = 32;
    localparam int FMT_W     = 2;
    localparam int LANE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int HELD_N    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_FORMAT = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_IMAGE_HEIGHT = 3'd2,
        REG_TOP_DOWN     = 3'd3,
        REG_RED_MASK     = 3'd4,
        REG_GREEN_MASK   = 3'd5,
        REG_BLUE_MASK    = 3'd6,
        REG_ALPHA_MASK   = 3'd7
    } t_reg_idx;

    localparam logic [MASK_W-1:0] LANE0_MASK = 32'h0000_00ff;
    localparam logic [MASK_W-1:0] LANE1_MASK = 32'h0000_ff00;
    localparam logic [MASK_W-1:0] LANE2_MASK = 32'h00ff_0000;
    localparam logic [MASK_W-1:0] LANE3_MASK = 32'hff00_0000;

    localparam logic [FMT_W-1:0]  FMT_RESET    = 2'd2;
    localparam logic [DIM_W-1:0]  DIM_RESET    = 13'd1;
    localparam logic [MASK_W-1:0] RED_RESET    = LANE3_MASK;
    localparam logic [MASK_W-1:0] GREEN_RESET  = LANE2_MASK;
    localparam logic [MASK_W-1:0] BLUE_RESET   = LANE1_MASK;
    localparam logic [MASK_W-1:0] ALPHA_RESET  = LANE0_MASK;

    localparam logic [LANE_W-1:0] LANE_0 = 2'd0;
    localparam logic [LANE_W-1:0] LANE_1 = 2'd1;
    localparam logic [LANE_W-1:0] LANE_2 = 2'd2;
    localparam logic [LANE_W-1:0] LANE_3 = 2'd3;

    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hff;

    typedef struct packed {
        logic [FMT_W-1:0]  pixel_format;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic              top_down;
        logic [MASK_W-1:0] red_mask;
        logic [MASK_W-1:0] green_mask;
        logic [MASK_W-1:0] blue_mask;
        logic [MASK_W-1:0] alpha_mask;
    } t_cfg;

    typedef struct packed {
        logic              hit;
        logic [LANE_W-1:0] idx;
    } t_lane;

    typedef struct packed {
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] out_row;
        logic               last_pixel;
    } t_pix;

    function automatic t_lane lane_of_mask(input logic [MASK_W-1:0] m);
        t_lane l;
        l.hit = 1'b1;
        l.idx = LANE_0;
        case (m)
            LANE0_MASK: l.idx = LANE_0;
            LANE1_MASK: l.idx = LANE_1;
            LANE2_MASK: l.idx = LANE_2;
            LANE3_MASK: l.idx = LANE_3;
            default:    l.hit = 1'b0;
        endcase
        return l;
    endfunction

endpackage

// ----- src/bpu_ifs.sv -----
interface bpu_in_if;
    import bpu_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] raw_byte;

    modport source (output valid, output raw_byte, input ready);
    modport sink   (input valid, input raw_byte, output ready);
endinterface

interface bpu_out_if;
    import bpu_pkg::*;
    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  alpha;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] out_row;
    logic               last_pixel;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output column, output out_row, output last_pixel, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input column, input out_row, input last_pixel, output ready);
endinterface

interface bpu_cfg_if;
    import bpu_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MASK_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/bmp_pixel_unpacker.sv -----
// A pixel enters the result buffer when its last byte is taken; padding bytes and
// non-final pixel bytes give no result. Throughput: one byte per cycle unless the
// two-entry result buffer is full; it keeps input flowing while the output is stalled.
// Reset (synchronous, active low) restores register defaults (32 bpp, 1x1, bottom-up,
// default masks), clears all position counters and empties the result buffer.
module bmp_pixel_unpacker #(
    parameter int MAX_WIDTH  = bpu_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bpu_pkg::DEF_MAX_HEIGHT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpu_in_if.sink    i_pix,
    bpu_out_if.source o_pix,
    bpu_cfg_if.sink   i_cfg
);
    import bpu_pkg::*;

    t_cfg  cfg;
    t_pix  trk_pix;
    t_pix  buf_pix;
    logic  trk_emit;
    logic  buf_full;
    logic  buf_valid;
    logic  in_acc;
    logic  cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    assign i_pix.ready = !buf_full;
    assign in_acc      = i_pix.valid && i_pix.ready;

    bpu_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cfg_wr),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    bpu_tracker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_trk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_acc   (in_acc),
        .i_byte  (i_pix.raw_byte),
        .o_emit  (trk_emit),
        .o_pix   (trk_pix)
    );

    bpu_out_fifo u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_acc && trk_emit),
        .i_pix   (trk_pix),
        .i_pop   (o_pix.ready),
        .o_valid (buf_valid),
        .o_full  (buf_full),
        .o_pix   (buf_pix)
    );

    assign o_pix.valid      = buf_valid;
    assign o_pix.red        = buf_pix.red;
    assign o_pix.green      = buf_pix.green;
    assign o_pix.blue       = buf_pix.blue;
    assign o_pix.alpha      = buf_pix.alpha;
    assign o_pix.column     = buf_pix.column;
    assign o_pix.out_row    = buf_pix.out_row;
    assign o_pix.last_pixel = buf_pix.last_pixel;

endmodule

// ----- src/bpu_cfg_regs.sv -----
module bpu_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [bpu_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [bpu_pkg::MASK_W-1:0]    i_data,
    output bpu_pkg::t_cfg                 o_cfg
);
    import bpu_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (t_reg_idx'(i_index))
                REG_PIXEL_FORMAT: n_cfg.pixel_format = i_data[FMT_W-1:0];
                REG_IMAGE_WIDTH:  n_cfg.image_width  = i_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: n_cfg.image_height = i_data[DIM_W-1:0];
                REG_TOP_DOWN:     n_cfg.top_down     = i_data[0];
                REG_RED_MASK:     n_cfg.red_mask     = i_data;
                REG_GREEN_MASK:   n_cfg.green_mask   = i_data;
                REG_BLUE_MASK:    n_cfg.blue_mask    = i_data;
                REG_ALPHA_MASK:   n_cfg.alpha_mask   = i_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format <= FMT_RESET;
            r_cfg.image_width  <= DIM_RESET;
            r_cfg.image_height <= DIM_RESET;
            r_cfg.top_down     <= 1'b0;
            r_cfg.red_mask     <= RED_RESET;
            r_cfg.green_mask   <= GREEN_RESET;
            r_cfg.blue_mask    <= BLUE_RESET;
            r_cfg.alpha_mask   <= ALPHA_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/bpu_tracker.sv -----
module bpu_tracker #(
    parameter int MAX_WIDTH  = bpu_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bpu_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpu_pkg::t_cfg              i_cfg,
    input  logic                       i_acc,
    input  logic [bpu_pkg::CHAN_W-1:0] i_byte,
    output logic                       o_emit,
    output bpu_pkg::t_pix              o_pix
);
    import bpu_pkg::*;

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int BW   = WW + 2;                       // holds 4 * width
    localparam int RBW  = $clog2(4 * MAX_WIDTH);
    localparam int CW   = $clog2(4 * MAX_WIDTH + 1);
    localparam int CWW  = (WW > DIM_W) ? WW : DIM_W;
    localparam int CHW  = (HW > DIM_W) ? HW : DIM_W;
    localparam int CXW  = (CW > WW) ? CW : WW;

    logic [LANE_W-1:0] r_lane, n_lane;
    logic [RBW-1:0]    r_rbc,  n_rbc;
    logic [CW-1:0]     r_col,  n_col;
    logic [HW-1:0]     r_frc,  n_frc;
    logic [CHAN_W-1:0] r_held [HELD_N];
    logic [CHAN_W-1:0] n_held [HELD_N];

    logic [WW-1:0]     w;
    logic [HW-1:0]     h;
    logic              four;
    logic [BW-1:0]     w3;
    logic [BW:0]       w3_up;
    logic [BW-1:0]     data_bytes;
    logic [BW-1:0]     stride;
    logic              in_data;
    logic              pix_done;
    logic              row_done;
    logic              frc_wrap;
    logic [CHAN_W-1:0] lanes [4];
    t_lane             sel_r, sel_g, sel_b, sel_a;
    logic [HW-1:0]     orow;

    function automatic logic [CHAN_W-1:0] pick(input t_lane s, input logic nb4,
                                                input logic [CHAN_W-1:0] l0,
                                                input logic [CHAN_W-1:0] l1,
                                                input logic [CHAN_W-1:0] l2,
                                                input logic [CHAN_W-1:0] l3);
        logic [CHAN_W-1:0] v;
        v = CHAN_FULL;
        if (s.hit && (nb4 || s.idx != LANE_3)) begin
            case (s.idx)
                LANE_0:  v = l0;
                LANE_1:  v = l1;
                LANE_2:  v = l2;
                LANE_3:  v = l3;
                default: v = CHAN_FULL;
            endcase
        end
        return v;
    endfunction

    // Clamp dimensions: zero reads as one, oversize reads as the maximum
    always_comb begin
        if (i_cfg.image_width == '0)
            w = WW'(1);
        else if (CWW'(i_cfg.image_width) > CWW'(MAX_WIDTH))
            w = WW'(MAX_WIDTH);
        else
            w = WW'(i_cfg.image_width);
        if (i_cfg.image_height == '0)
            h = HW'(1);
        else if (CHW'(i_cfg.image_height) > CHW'(MAX_HEIGHT))
            h = HW'(MAX_HEIGHT);
        else
            h = HW'(i_cfg.image_height);
    end

    assign four  = i_cfg.pixel_format[1];
    assign w3    = BW'(w) + BW'({w, 1'b0});
    assign w3_up = (BW + 1)'(w3) + (BW + 1)'(3);
    assign data_bytes = four ? {BW'(w) << 2} : w3;
    // 24 bpp rows round up to a whole word
    assign stride = four ? {BW'(w) << 2} : BW'({w3_up[BW:2], 2'b00});

    assign in_data  = (BW'(r_rbc) < data_bytes);
    assign pix_done = four ? (r_lane == LANE_3) : (r_lane >= LANE_2);
    assign row_done = ((BW + 1)'(r_rbc) + (BW + 1)'(1)) >= (BW + 1)'(stride);
    assign frc_wrap = ((HW + 1)'(r_frc) + (HW + 1)'(1)) >= (HW + 1)'(h);

    always_comb begin
        n_lane = r_lane;
        n_rbc  = r_rbc;
        n_col  = r_col;
        n_frc  = r_frc;
        n_held = r_held;
        if (in_data) begin
            if (pix_done) begin
                n_lane = LANE_0;
                n_col  = r_col + CW'(1);
            end else begin
                if (r_lane != LANE_3)
                    n_held[r_lane] = i_byte;
                n_lane = r_lane + LANE_W'(1);
            end
        end
        if (row_done) begin
            n_rbc  = '0;
            n_lane = LANE_0;
            n_col  = '0;
            n_frc  = frc_wrap ? '0 : (r_frc + HW'(1));
        end else begin
            n_rbc  = r_rbc + RBW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= LANE_0;
            r_rbc  <= '0;
            r_col  <= '0;
            r_frc  <= '0;
            for (int i = 0; i < HELD_N; i++)
                r_held[i] <= '0;
        end else if (i_acc) begin
            r_lane <= n_lane;
            r_rbc  <= n_rbc;
            r_col  <= n_col;
            r_frc  <= n_frc;
            r_held <= n_held;
        end
    end

    // Pixel assembly: the current byte is the last lane of the pixel
    always_comb begin
        lanes[0] = r_held[0];
        lanes[1] = r_held[1];
        lanes[2] = four ? r_held[2] : i_byte;
        lanes[3] = four ? i_byte : '0;
    end

    always_comb begin
        if (i_cfg.pixel_format[0]) begin
            sel_r = lane_of_mask(i_cfg.red_mask);
            sel_g = lane_of_mask(i_cfg.green_mask);
            sel_b = lane_of_mask(i_cfg.blue_mask);
            sel_a = lane_of_mask(i_cfg.alpha_mask);
        end else begin
            sel_r = '{hit: 1'b1, idx: LANE_2};
            sel_g = '{hit: 1'b1, idx: LANE_1};
            sel_b = '{hit: 1'b1, idx: LANE_0};
            sel_a = '{hit: four, idx: LANE_3};
        end
    end

    always_comb begin
        if (r_frc >= h)
            orow = '0;
        else if (i_cfg.top_down)
            orow = r_frc;
        else
            orow = h - HW'(1) - r_frc;
    end

    always_comb begin
        o_pix.red        = pick(sel_r, four, lanes[0], lanes[1], lanes[2], lanes[3]);
        o_pix.green      = pick(sel_g, four, lanes[0], lanes[1], lanes[2], lanes[3]);
        o_pix.blue       = pick(sel_b, four, lanes[0], lanes[1], lanes[2], lanes[3]);
        o_pix.alpha      = pick(sel_a, four, lanes[0], lanes[1], lanes[2], lanes[3]);
        o_pix.column     = COORD_W'(r_col);
        o_pix.out_row    = COORD_W'(orow);
        o_pix.last_pixel = (CXW'(r_col) == (CXW'(w) - CXW'(1)))
                           && (r_frc == (h - HW'(1)));
    end

    assign o_emit = in_data && pix_done;

endmodule

// ----- src/bpu_out_fifo.sv -----
module bpu_out_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bpu_pkg::t_pix i_pix,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output bpu_pkg::t_pix o_pix
);
    import bpu_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    t_pix           r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [NW-1:0]  r_cnt;
    logic           do_pop;

    assign do_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wr <= r_wr + PW'(1);
            if (do_pop)
                r_rd <= r_rd + PW'(1);
            if (i_push && !do_pop)
                r_cnt <= r_cnt + NW'(1);
            else if (!i_push && do_pop)
                r_cnt <= r_cnt - NW'(1);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_pix   = r_mem[r_rd];

endmodule

// ----- tb/tb_bmp_pixel_unpacker.sv -----
module tb_bmp_pixel_unpacker;
    timeunit 1ns;
    timeprecision 1ps;
    import bpu_pkg::*;

    localparam int unsigned NO_LANE = 255;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned RANDOM_BYTES = 750;

    localparam logic [FMT_W-1:0] FMT_24_PLAIN  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_24_FIELDS = 2'd1;
    localparam logic [FMT_W-1:0] FMT_32_PLAIN  = 2'd2;
    localparam logic [FMT_W-1:0] FMT_32_FIELDS = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bpu_in_if  pix_in ();
    bpu_out_if pix_out ();
    bpu_cfg_if cfg_bus ();

    bmp_pixel_unpacker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .i_cfg   (cfg_bus)
    );

    always #2 i_clk = ~i_clk;

    // shadow registers and decoder position
    t_cfg        regs;
    int unsigned byte_in_pixel;
    int unsigned byte_in_row;
    int unsigned pixel_in_row;
    int unsigned stored_row;
    logic [7:0]  held [HELD_N];

    t_pix        pending_pixels [$];
    t_pix        oldest_pixel;
    int unsigned failures = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned burst_left = 0;
    int unsigned rx_cycle = 0;
    int unsigned stall_left = 0;

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic int unsigned lane_for_mask(logic [MASK_W-1:0] m);
        case (m)
            LANE0_MASK: return 0;
            LANE1_MASK: return 1;
            LANE2_MASK: return 2;
            LANE3_MASK: return 3;
            default:    return NO_LANE;
        endcase
    endfunction

    function automatic int unsigned pixel_bytes();
        return (regs.pixel_format >= FMT_32_PLAIN) ? 4 : 3;
    endfunction

    function automatic int unsigned row_stride();
        int unsigned w;
        w = clamp_dim(regs.image_width, DEF_MAX_WIDTH);
        return ((pixel_bytes() * 8 * w + 31) / 32) * 4;
    endfunction

    function automatic int unsigned image_bytes();
        return row_stride() * clamp_dim(regs.image_height, DEF_MAX_HEIGHT);
    endfunction

    function automatic logic [MASK_W-1:0] random_mask();
        logic [MASK_W-1:0] lane;
        case ($urandom_range(0, 3))
            0:       lane = LANE0_MASK;
            1:       lane = LANE1_MASK;
            2:       lane = LANE2_MASK;
            default: lane = LANE3_MASK;
        endcase
        case ($urandom_range(0, 9))
            6:       return '0;
            7:       return $urandom();
            8:       return lane ^ (32'h1 << $urandom_range(0, 31));
            9:       return '1;
            default: return lane;
        endcase
    endfunction

    task automatic reset_decoder_model();
        regs.pixel_format = FMT_RESET;
        regs.image_width  = DIM_RESET;
        regs.image_height = DIM_RESET;
        regs.top_down     = 1'b0;
        regs.red_mask     = RED_RESET;
        regs.green_mask   = GREEN_RESET;
        regs.blue_mask    = BLUE_RESET;
        regs.alpha_mask   = ALPHA_RESET;
        byte_in_pixel = 0;
        byte_in_row   = 0;
        pixel_in_row  = 0;
        stored_row    = 0;
        foreach (held[i]) held[i] = 8'h00;
    endtask

    // Advance the decoder model by one accepted byte; queue a pixel when one completes.
    task automatic unpack_byte(input logic [7:0] b);
        int unsigned w, h, nb, stride, rl, gl, bl, al, orow;
        logic [7:0]  lanes [4];
        t_pix        px;
        w      = clamp_dim(regs.image_width, DEF_MAX_WIDTH);
        h      = clamp_dim(regs.image_height, DEF_MAX_HEIGHT);
        nb     = pixel_bytes();
        stride = row_stride();
        if (byte_in_row < nb * w) begin
            if (byte_in_pixel + 1 >= nb) begin
                lanes[0] = held[0];
                lanes[1] = held[1];
                lanes[2] = held[2];
                lanes[nb-1] = b;
                lanes[3] = (nb == 4) ? b : 8'h00;
                if (regs.pixel_format[0]) begin
                    rl = lane_for_mask(regs.red_mask);
                    gl = lane_for_mask(regs.green_mask);
                    bl = lane_for_mask(regs.blue_mask);
                    al = lane_for_mask(regs.alpha_mask);
                end else begin
                    rl = 2;
                    gl = 1;
                    bl = 0;
                    al = (nb == 4) ? 3 : NO_LANE;
                end
                if (stored_row >= h) begin
                    orow = 0;
                end else if (regs.top_down) begin
                    orow = stored_row;
                end else begin
                    orow = h - 1 - stored_row;
                end
                // a lane past the pixel's last byte reads as full scale
                px.red        = (rl < nb) ? lanes[rl] : CHAN_FULL;
                px.green      = (gl < nb) ? lanes[gl] : CHAN_FULL;
                px.blue       = (bl < nb) ? lanes[bl] : CHAN_FULL;
                px.alpha      = (al < nb) ? lanes[al] : CHAN_FULL;
                px.column     = COORD_W'(pixel_in_row);
                px.out_row    = COORD_W'(orow);
                px.last_pixel = (pixel_in_row == w - 1) && (stored_row == h - 1);
                pending_pixels.push_back(px);
                byte_in_pixel = 0;
                pixel_in_row++;
            end else begin
                if (byte_in_pixel < 3) held[byte_in_pixel] = b;
                byte_in_pixel++;
            end
        end
        if (byte_in_row + 1 >= stride) begin
            byte_in_row   = 0;
            byte_in_pixel = 0;
            pixel_in_row  = 0;
            stored_row    = (stored_row + 1 >= h) ? 0 : stored_row + 1;
        end else begin
            byte_in_row++;
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [MASK_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            REG_PIXEL_FORMAT: regs.pixel_format = value[FMT_W-1:0];
            REG_IMAGE_WIDTH:  regs.image_width  = value[DIM_W-1:0];
            REG_IMAGE_HEIGHT: regs.image_height = value[DIM_W-1:0];
            REG_TOP_DOWN:     regs.top_down     = value[0];
            REG_RED_MASK:     regs.red_mask     = value;
            REG_GREEN_MASK:   regs.green_mask   = value;
            REG_BLUE_MASK:    regs.blue_mask    = value;
            REG_ALPHA_MASK:   regs.alpha_mask   = value;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic set_geometry(input logic [MASK_W-1:0] fmt, input logic [MASK_W-1:0] width,
                                input logic [MASK_W-1:0] height, input logic [MASK_W-1:0] top);
        write_reg(REG_PIXEL_FORMAT, fmt);
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
        write_reg(REG_TOP_DOWN, top);
    endtask

    // Sender works in bursts; valid stays high across a burst.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                pix_in.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        pix_in.valid    = 1'b1;
        pix_in.raw_byte = b;
        do @(posedge i_clk); while (!pix_in.ready);
        unpack_byte(b);
        bytes_sent++;
    endtask

    task automatic send_random_bytes(input int unsigned n);
        repeat (n) send_byte($urandom_range(0, 255));
    endtask

    // run the stream on until the decoder is back at the start of an image
    task automatic finish_image();
        while (byte_in_row != 0 || stored_row != 0) send_byte($urandom_range(0, 255));
    endtask

    // drop valid, drain all pending pixels, then allow for the output stage
    task automatic settle();
        @(negedge i_clk);
        pix_in.valid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic test_default_format();
        // out of reset: 32 bpp, 1x1, bottom-up, default lanes
        send_byte(8'h00);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'hff);
        settle();
        // upper data bits are ignored by the narrow registers
        set_geometry(32'hffff_fffc, 32'hfffe_0002, 32'd1, 32'd1);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h7f);
        send_byte(8'hfe);
        send_byte(8'hff);
        send_byte(8'h00);
        settle();
    endtask

    task automatic test_lane_masks();
        // 24 bpp bitfields: lane three missing, bad mask, alpha on its own lane
        set_geometry(FMT_24_FIELDS, 32'd0, 32'd0, 32'd0);
        write_reg(REG_RED_MASK, LANE0_MASK);
        write_reg(REG_GREEN_MASK, LANE3_MASK);
        write_reg(REG_BLUE_MASK, 32'h0000_ff01);
        write_reg(REG_ALPHA_MASK, LANE1_MASK);
        send_byte(8'h5a);
        send_byte(8'ha5);
        send_byte(8'hc3);
        send_byte(8'h3c);
        settle();
        write_reg(REG_PIXEL_FORMAT, FMT_32_FIELDS);
        write_reg(REG_IMAGE_HEIGHT, 32'd2);
        write_reg(REG_RED_MASK, LANE3_MASK);
        write_reg(REG_GREEN_MASK, LANE0_MASK);
        write_reg(REG_BLUE_MASK, LANE2_MASK);
        write_reg(REG_ALPHA_MASK, 32'hffff_ffff);
        send_random_bytes(8);
        settle();
    endtask

    task automatic test_dimension_clamps();
        // width beyond the maximum, then shrunk mid-row
        set_geometry(FMT_24_PLAIN, 32'h0000_1fff, 32'd1, 32'd0);
        send_random_bytes(12);
        settle();
        write_reg(REG_IMAGE_WIDTH, 32'd2);
        finish_image();
        settle();
        // tallest image bottom-up, then height cut below the current stored row
        set_geometry(FMT_32_PLAIN, 32'd1, 32'h0000_1fff, 32'd0);
        send_random_bytes(12);
        settle();
        write_reg(REG_IMAGE_HEIGHT, 32'd2);
        finish_image();
        settle();
    endtask

    task automatic test_random_images();
        int unsigned start, size, w, h, cut;
        t_reg_idx    idx;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            case ($urandom_range(0, 15))
                0:       w = 0;
                1:       w = $urandom_range(9, 48);
                default: w = $urandom_range(1, 8);
            endcase
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            set_geometry($urandom_range(0, 3), w, h, $urandom_range(0, 1));
            if ($urandom_range(0, 1)) begin
                write_reg(REG_RED_MASK, random_mask());
                write_reg(REG_GREEN_MASK, random_mask());
                write_reg(REG_BLUE_MASK, random_mask());
                write_reg(REG_ALPHA_MASK, random_mask());
            end
            size = image_bytes();
            if (size > 1 && $urandom_range(0, 9) == 0) begin
                // image broken off by a register change
                cut = $urandom_range(1, size - 1);
                send_random_bytes(cut);
                settle();
                idx = t_reg_idx'($urandom_range(0, 7));
                case (idx)
                    REG_PIXEL_FORMAT: write_reg(idx, $urandom_range(0, 3));
                    REG_IMAGE_WIDTH:  write_reg(idx, $urandom_range(1, 8));
                    REG_IMAGE_HEIGHT: write_reg(idx, $urandom_range(1, 4));
                    REG_TOP_DOWN:     write_reg(idx, $urandom_range(0, 1));
                    default:          write_reg(idx, random_mask());
                endcase
                finish_image();
            end else begin
                send_random_bytes(size);
            end
            settle();
        end
    endtask

    task automatic test_wide_row();
        // one long 24 bpp row, padded when the width is not a multiple of four
        set_geometry(FMT_24_PLAIN, $urandom_range(60, 90), 32'd1, $urandom_range(0, 1));
        send_random_bytes(image_bytes());
        settle();
    endtask

    // receiver: full rate, random stalls, and rare long stalls in turn
    initial begin
        pix_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (stall_left > 0) begin
                stall_left--;
                pix_out.ready = 1'b0;
            end else begin
                case ((rx_cycle / 300) % 3)
                    0: pix_out.ready = 1'b1;
                    1: pix_out.ready = ($urandom_range(0, 3) != 0);
                    default: begin
                        if ($urandom_range(0, 15) == 0) begin
                            stall_left    = $urandom_range(1, 20);
                            pix_out.ready = 1'b0;
                        end else begin
                            pix_out.ready = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel with no expectation: column %0d, row %0d",
                       pix_out.column, pix_out.out_row);
                failures++;
            end else begin
                oldest_pixel = pending_pixels.pop_front();
                check_field("red", oldest_pixel.red, pix_out.red);
                check_field("green", oldest_pixel.green, pix_out.green);
                check_field("blue", oldest_pixel.blue, pix_out.blue);
                check_field("alpha", oldest_pixel.alpha, pix_out.alpha);
                check_field("column", oldest_pixel.column, pix_out.column);
                check_field("out_row", oldest_pixel.out_row, pix_out.out_row);
                check_field("last_pixel", oldest_pixel.last_pixel, pix_out.last_pixel);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        pix_in.valid    = 1'b0;
        pix_in.raw_byte = 8'h00;
        cfg_bus.valid   = 1'b0;
        cfg_bus.index   = REG_PIXEL_FORMAT;
        cfg_bus.data    = '0;
        reset_decoder_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_format();
        test_lane_masks();
        test_dimension_clamps();
        test_random_images();
        test_wide_row();

        settle();
        repeat (10) @(posedge i_clk);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
